@@ rtl/isr_pkg.sv @@
// Shared constants and helpers for the integer square root core.
// No dependencies; imported by the core, its stages and its checker.
`default_nettype none

package isr_pkg;

  // Width of the root field on the output port.
  localparam int unsigned ROOT_WIDTH = 16;

  // Number of root bits (one pipeline stage each) for a radicand width:
  // the top trial bit sits at the highest even position below the width.
  function automatic int unsigned isr_steps(input int unsigned width);
    int unsigned w;
    w = width;
    if (w > 64) w = 64;
    if (w < 2) w = 2;
    return (((w - 1) & ~32'd1) >> 1) + 1;
  endfunction

endpackage

`default_nettype wire

@@ rtl/isr_stage.sv @@
// One digit step of the square root pipeline: trial subtract and root bit.
// Depends on isr_pkg for the common import convention only.
`default_nettype none

module isr_stage import isr_pkg::*; #(
  parameter int unsigned CalcWidth = 32,
  parameter int unsigned RootBits  = 16,
  parameter int unsigned Shift     = 0
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 adv_i,
  input  wire logic                 valid_i,
  input  wire logic [CalcWidth-1:0] rem_i,
  input  wire logic [RootBits-1:0]  q_i,
  output logic                      valid_o,
  output logic [CalcWidth-1:0]      rem_o,
  output logic [RootBits-1:0]       q_o
);

  logic                 valid_q;
  logic [CalcWidth-1:0] rem_q, rem_d, trial;
  logic [RootBits-1:0]  q_q, q_d;
  logic                 ge;

  // Trial value: (4*q + 1) aligned to the current bit pair.
  always_comb begin
    trial = CalcWidth'({q_i, 2'b01}) << Shift;
    ge    = (rem_i >= trial);
    rem_d = ge ? (rem_i - trial) : rem_i;
    q_d   = RootBits'({q_i, ge});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (adv_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      rem_q <= rem_d;
      q_q   <= q_d;
    end
  end

  assign valid_o = valid_q;
  assign rem_o   = rem_q;
  assign q_o     = q_q;

endmodule

`default_nettype wire

@@ rtl/integer_square_root_core.sv @@
// Pipelined floor square root of an unsigned radicand, one root bit per stage.
// Depends on isr_pkg and isr_stage.
//
//   channel  | direction | handshake          | payload
//   ---------+-----------+--------------------+----------------------------
//   request  | in        | valid_i / stall_o  | radicand_i [RADICAND_WIDTH]
//   result   | out       | valid_o / stall_i  | root_o [16]
//
// One request enters per cycle unless stall_o is high; the stage count is Steps,
// Steps = ((RADICAND_WIDTH-1) rounded down to even)/2 + 1, i.e. 16 at width 32.
// Each stage holds one trial subtract and compare over the remainder width.
// Reset clears only the stage valid bits; data registers carry no reset.
// A stall on the result side freezes the whole pipeline while the last stage
// holds a result; stall_o then rises so no request is taken or dropped.
`default_nettype none

module integer_square_root_core import isr_pkg::*; #(
  parameter int unsigned RADICAND_WIDTH = 32
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      valid_i,
  output logic                           stall_o,
  input  wire logic [RADICAND_WIDTH-1:0] radicand_i,
  output logic                           valid_o,
  input  wire logic                      stall_i,
  output logic [ROOT_WIDTH-1:0]          root_o
);

  // One stage per root bit; the remainder path is two bits per root bit wide.
  localparam int unsigned Steps     = isr_steps(RADICAND_WIDTH);
  localparam int unsigned RootBits  = Steps;
  localparam int unsigned CalcWidth = 2 * Steps;

  logic                 vld [Steps+1];
  logic [CalcWidth-1:0] rem [Steps];
  logic [RootBits-1:0]  q   [Steps+1];
  logic                 adv;

  // Advance everything unless the finished result is being held.
  assign adv     = !(vld[Steps] && stall_i);
  assign stall_o = !adv;

  // Feed stage zero: zero partial root, radicand as the first remainder.
  assign vld[0] = valid_i;
  assign rem[0] = CalcWidth'(radicand_i);
  assign q[0]   = '0;

  for (genvar k = 0; k < Steps; k++) begin : g_stage
    if (k < Steps - 1) begin : g_mid
      isr_stage #(
        .CalcWidth (CalcWidth),
        .RootBits  (RootBits),
        .Shift     (2 * (Steps - 1 - k))
      ) u_stage (
        .clk_i   (clk_i),
        .rst_ni  (rst_ni),
        .adv_i   (adv),
        .valid_i (vld[k]),
        .rem_i   (rem[k]),
        .q_i     (q[k]),
        .valid_o (vld[k+1]),
        .rem_o   (rem[k+1]),
        .q_o     (q[k+1])
      );
    end else begin : g_last
      // Final remainder is not needed downstream; drop it.
      isr_stage #(
        .CalcWidth (CalcWidth),
        .RootBits  (RootBits),
        .Shift     (0)
      ) u_stage (
        .clk_i   (clk_i),
        .rst_ni  (rst_ni),
        .adv_i   (adv),
        .valid_i (vld[k]),
        .rem_i   (rem[k]),
        .q_i     (q[k]),
        .valid_o (vld[k+1]),
        .rem_o   (),
        .q_o     (q[k+1])
      );
    end
  end

  assign valid_o = vld[Steps];

  // Keep the low root bits; widen with zeros for narrow radicands.
  if (RootBits >= ROOT_WIDTH) begin : g_root_trunc
    assign root_o = q[Steps][ROOT_WIDTH-1:0];
  end else begin : g_root_ext
    assign root_o = ROOT_WIDTH'(q[Steps]);
  end

endmodule

`default_nettype wire

@@ rtl/isr_checker.sv @@
// Port-level checks for integer_square_root_core, bound to the top level.
// Depends on isr_pkg for the root width.
`default_nettype none

module isr_checker import isr_pkg::*; (
  input wire logic                  clk_i,
  input wire logic                  rst_ni,
  input wire logic                  valid_i,
  input wire logic                  stall_o,
  input wire logic                  valid_o,
  input wire logic                  stall_i,
  input wire logic [ROOT_WIDTH-1:0] root_o
);

  // Hold a stalled result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && stall_i |=> valid_o)
    else $error("result dropped under stall");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && stall_i |=> $stable(root_o))
    else $error("stalled root changed");

  // Back-pressure toward requests only when a result is actually held.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    stall_o |-> valid_o && stall_i)
    else $error("request stalled without a held result");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && !stall_i |-> !stall_o)
    else $error("request stalled while result drains");

  // A request taken during a freeze would be lost.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    stall_o && valid_i |=> valid_o)
    else $error("pipeline released with pending request blocked and no result");

endmodule

bind integer_square_root_core isr_checker u_isr_checker (
  .clk_i   (clk_i),
  .rst_ni  (rst_ni),
  .valid_i (valid_i),
  .stall_o (stall_o),
  .valid_o (valid_o),
  .stall_i (stall_i),
  .root_o  (root_o)
);

`default_nettype wire
